// ----- hdl/plbr_pkg.sv -----
package plbr_pkg;

  // payload widths of the request and result channels
  localparam int unsigned OpW   = 2;
  localparam int unsigned PosW  = 6;
  localparam int unsigned CharW = 8;
  localparam int unsigned StatW = 2;

  typedef enum logic [OpW-1:0] {
    OP_ADD   = 2'd0,
    OP_DEL   = 2'd1,
    OP_GET   = 2'd2,
    OP_PRINT = 2'd3
  } op_e;

  typedef enum logic [StatW-1:0] {
    ST_OK     = 2'd0,
    ST_BADPOS = 2'd1,
    ST_FULL   = 2'd2,
    ST_EMPTY  = 2'd3
  } status_e;

  // command broadcast from the controller to every cell of the row
  typedef struct packed {
    logic             ins;
    logic             del;
    logic [PosW-1:0]  idx;
    logic [CharW-1:0] ch;
  } cell_cmd_t;

endpackage

// ----- hdl/plbr_if.sv -----
interface plbr_req_if import plbr_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [OpW-1:0]   operation;
  logic [PosW-1:0]  position;
  logic [CharW-1:0] char_in;

  modport source (output valid, output operation, output position, output char_in,
                  input ready);
  modport sink   (input valid, input operation, input position, input char_in,
                  output ready);
endinterface

interface plbr_rsp_if import plbr_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [StatW-1:0] status;
  logic [CharW-1:0] char_out;
  logic             last;

  modport source (output valid, output status, output char_out, output last,
                  input ready);
  modport sink   (input valid, input status, input char_out, input last,
                  output ready);
endinterface

// ----- hdl/plbr_cell.sv -----
module plbr_cell import plbr_pkg::*; #(
  parameter int unsigned CellIdx = 0
) (
  input  logic             clk_i,
  input  cell_cmd_t        cmd_i,
  input  logic [CharW-1:0] left_i,
  input  logic [CharW-1:0] right_i,
  output logic [CharW-1:0] data_o
);

  localparam logic [PosW-1:0] Here = PosW'(CellIdx);

  logic [CharW-1:0] data_d, data_q;

  // insert shifts up from the left neighbour, delete pulls from the right one
  always_comb begin
    data_d = data_q;
    priority if (cmd_i.ins && (Here > cmd_i.idx)) begin
      data_d = left_i;
    end else if (cmd_i.ins && (Here == cmd_i.idx)) begin
      data_d = cmd_i.ch;
    end else if (cmd_i.del && (Here >= cmd_i.idx)) begin
      data_d = right_i;
    end else begin
      data_d = data_q;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

// ----- hdl/positional_list_by_rank_unit.sv -----
// add, delete, get and an empty print give their result in the cycle after acceptance
// print of n bytes: acceptance sets busy; from then one byte per cycle while the result is not stalled
// one add, delete or get per cycle unless the result stalls; a print blocks requests until its last byte is loaded
// the row of cells shifts the list at and above the position in the cycle of an add or delete
// reset (rst_ni low, asynchronous) empties the list; stored bytes keep no reset value
module positional_list_by_rank_unit import plbr_pkg::*; #(
  parameter int unsigned CAPACITY = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  plbr_req_if.sink           req_i,
  plbr_rsp_if.source         rsp_o
);

  localparam int unsigned CntW = $clog2(CAPACITY + 1);
  localparam int unsigned IdxW = $clog2(CAPACITY);
  localparam int unsigned CmpW = ((CntW > PosW) ? CntW : PosW) + 1;

  logic [CntW-1:0]  count_d, count_q;
  logic             busy_d, busy_q;
  logic [IdxW-1:0]  ptr_d, ptr_q;
  logic             ovalid_d, ovalid_q;
  logic [StatW-1:0] ostat_d, ostat_q;
  logic [CharW-1:0] ochar_d, ochar_q;
  logic             olast_d, olast_q;

  logic             out_free, acc;
  logic [PosW-1:0]  idx;
  logic [CmpW-1:0]  pos_c, cnt_c;
  logic             pos_zero, add_bad, rd_bad, full, ptr_last;
  cell_cmd_t        cmd;
  logic [CharW-1:0] cell_data [CAPACITY];

  // handshake
  assign out_free    = !ovalid_q || rsp_o.ready;
  assign req_i.ready = !busy_q && out_free;
  assign acc         = req_i.valid && req_i.ready;

  // rank checks
  assign idx      = req_i.position - PosW'(1);
  assign pos_c    = CmpW'(req_i.position);
  assign cnt_c    = CmpW'(count_q);
  assign pos_zero = (req_i.position == '0);
  assign add_bad  = pos_zero || (pos_c > (cnt_c + CmpW'(1)));
  assign rd_bad   = pos_zero || (pos_c > cnt_c);
  assign full     = (count_q == CntW'(CAPACITY));
  assign ptr_last = ((CntW'(ptr_q) + CntW'(1)) == count_q);

  // command to the row of cells
  always_comb begin
    cmd.ins = acc && (req_i.operation == OP_ADD) && !add_bad && !full;
    cmd.del = acc && (req_i.operation == OP_DEL) && !rd_bad;
    cmd.idx = idx;
    cmd.ch  = req_i.char_in;
  end

  // row of cells
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [CharW-1:0] left, right;
    if (g == 0) begin : g_first
      assign left = '0;
    end else begin : g_mid_l
      assign left = cell_data[g-1];
    end
    if (g == CAPACITY - 1) begin : g_end
      assign right = '0;
    end else begin : g_mid_r
      assign right = cell_data[g+1];
    end
    plbr_cell #(.CellIdx(g)) u_cell (
      .clk_i  (clk_i),
      .cmd_i  (cmd),
      .left_i (left),
      .right_i(right),
      .data_o (cell_data[g])
    );
  end

  // fill count
  always_comb begin
    count_d = count_q;
    if (cmd.ins) begin
      count_d = count_q + CntW'(1);
    end else if (cmd.del) begin
      count_d = count_q - CntW'(1);
    end
  end

  // result register and print sequencer
  always_comb begin
    busy_d   = busy_q;
    ptr_d    = ptr_q;
    ovalid_d = ovalid_q;
    ostat_d  = ostat_q;
    ochar_d  = ochar_q;
    olast_d  = olast_q;
    priority if (busy_q && out_free) begin
      ovalid_d = 1'b1;
      ostat_d  = ST_OK;
      ochar_d  = cell_data[ptr_q];
      olast_d  = ptr_last;
      ptr_d    = ptr_q + IdxW'(1);
      busy_d   = !ptr_last;
    end else if (acc) begin
      ovalid_d = 1'b1;
      ochar_d  = '0;
      olast_d  = 1'b1;
      unique case (req_i.operation)
        OP_ADD: begin
          ostat_d = add_bad ? ST_BADPOS : (full ? ST_FULL : ST_OK);
        end
        OP_DEL: begin
          ostat_d = rd_bad ? ST_BADPOS : ST_OK;
        end
        OP_GET: begin
          ostat_d = rd_bad ? ST_BADPOS : ST_OK;
          ochar_d = rd_bad ? '0 : cell_data[idx[IdxW-1:0]];
        end
        default: begin
          if (count_q == '0) begin
            ostat_d = ST_EMPTY;
          end else begin
            ovalid_d = 1'b0;
            busy_d   = 1'b1;
            ptr_d    = '0;
          end
        end
      endcase
    end else if (out_free) begin
      ovalid_d = 1'b0;
    end else begin
      ovalid_d = ovalid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      busy_q   <= 1'b0;
      ptr_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      count_q  <= count_d;
      busy_q   <= busy_d;
      ptr_q    <= ptr_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ostat_q <= ostat_d;
    ochar_q <= ochar_d;
    olast_q <= olast_d;
  end

  assign rsp_o.valid    = ovalid_q;
  assign rsp_o.status   = ostat_q;
  assign rsp_o.char_out = ochar_q;
  assign rsp_o.last     = olast_q;

endmodule

// ----- hdl/plbr_checker.sv -----
module plbr_checker import plbr_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             req_valid_i,
  input logic             req_ready_i,
  input logic [OpW-1:0]   req_operation_i,
  input logic             rsp_valid_i,
  input logic             rsp_ready_i,
  input logic [StatW-1:0] rsp_status_i,
  input logic [CharW-1:0] rsp_char_out_i,
  input logic             rsp_last_i
);

  // a stalled result stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i)
    else $error("result withdrawn while stalled");

  // a stalled result keeps its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=>
      $stable(rsp_status_i) && $stable(rsp_char_out_i) && $stable(rsp_last_i))
    else $error("result payload changed while stalled");

  // no request is taken in the middle of a print stream
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_last_i |-> !req_ready_i)
    else $error("request accepted during print");

  // a single-result request answers in the next cycle, marked last
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i && (req_operation_i != OP_PRINT) |=>
      rsp_valid_i && rsp_last_i)
    else $error("single result missing or not marked last");

endmodule

bind positional_list_by_rank_unit plbr_checker u_plbr_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .req_valid_i    (req_i.valid),
  .req_ready_i    (req_i.ready),
  .req_operation_i(req_i.operation),
  .rsp_valid_i    (rsp_o.valid),
  .rsp_ready_i    (rsp_o.ready),
  .rsp_status_i   (rsp_o.status),
  .rsp_char_out_i (rsp_o.char_out),
  .rsp_last_i     (rsp_o.last)
);
